// ----- rtl/cspan_pkg.sv -----
// shared types and constants for the column to row span extractor
// no dependencies; imported by the interfaces, controller and datapath
package cspan_pkg;

    localparam int CW = 10;
    localparam int RW = 6;

    typedef logic [CW-1:0] t_col;
    typedef logic [RW-1:0] t_row;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_bot;
        logic emit;
        logic emit_bot;
        logic open_top;
        logic open_bot;
    } t_cmd;

    // loop conditions and output status back to the controller
    typedef struct packed {
        logic close_top;
        logic close_bot;
        logic open_top;
        logic open_bot;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/cspan_if.sv -----
// valid/ready channel interfaces for column items and span results
// depends on cspan_pkg
interface cspan_in_if import cspan_pkg::*; ();
    logic valid;
    logic ready;
    t_col column;
    t_row column_top;
    t_row column_bottom;
    logic column_empty;
    logic plane_start;

    modport source(output valid, column, column_top, column_bottom, column_empty, plane_start,
                   input ready);
    modport sink(input valid, column, column_top, column_bottom, column_empty, plane_start,
                 output ready);
endinterface

interface cspan_out_if import cspan_pkg::*; ();
    logic valid;
    logic ready;
    t_row span_row;
    t_col span_first;
    t_col span_final;
    logic last;

    modport source(output valid, span_row, span_first, span_final, last, input ready);
    modport sink(input valid, span_row, span_first, span_final, last, output ready);
endinterface

// ----- rtl/cspan_ctrl.sv -----
// sequencer for the four row walks: close top, close bottom, open top, open bottom
// depends on cspan_pkg
module cspan_ctrl import cspan_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CTOP = 7'b0000010,
        S_ETOP = 7'b0000100,
        S_CBOT = 7'b0001000,
        S_EBOT = 7'b0010000,
        S_OTOP = 7'b0100000,
        S_OBOT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CTOP;
                end
            end
            S_CTOP: begin
                if (i_status.close_top) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_ETOP;
                end else begin
                    n_state = S_CBOT;
                end
            end
            S_ETOP: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CTOP;
                end
            end
            S_CBOT: begin
                if (i_status.close_bot) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_bot = 1'b1;
                    n_state      = S_EBOT;
                end else begin
                    n_state = S_OTOP;
                end
            end
            S_EBOT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_bot = 1'b1;
                    n_state        = S_CBOT;
                end
            end
            S_OTOP: begin
                if (i_status.open_top) begin
                    o_cmd.open_top = 1'b1;
                end else begin
                    n_state = S_OBOT;
                end
            end
            S_OBOT: begin
                if (i_status.open_bot) begin
                    o_cmd.open_bot = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("span emitted while output register is occupied");

    a_read_not_repeated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> !o_cmd.rd_en)
        else $error("start read issued twice before its span was sent");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

endmodule

// ----- rtl/cspan_datapath.sv -----
// range registers, per-row span start memory and output register
// depends on cspan_pkg; driven by cspan_ctrl commands
module cspan_datapath import cspan_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  t_col    i_column,
    input  t_row    i_column_top,
    input  t_row    i_column_bottom,
    input  logic    i_column_empty,
    input  logic    i_plane_start,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_row    o_span_row,
    output t_col    o_span_first,
    output t_col    o_span_final,
    output logic    o_last
);

    localparam int RW1 = $clog2(ROWS + 1);
    localparam int RWI = $clog2(ROWS);
    localparam logic [RW1-1:0] ROWS_V  = RW1'(ROWS);
    localparam logic [RW1-1:0] ROW_MAX = RW1'(ROWS - 1);
    localparam t_col COL_SAT = CW'((COLS - 1) % (1 << CW));

    function automatic logic [RW1-1:0] clamp_row(t_row v);
        if (32'(v) >= 32'(ROWS)) begin
            return ROW_MAX;
        end
        return RW1'(v);
    endfunction

    t_col           r_col;
    logic [RW1-1:0] r_t1, r_b1, r_t2, r_b2;
    logic [RW1-1:0] r_prev_top, r_prev_bot;
    logic           r_prev_empty;
    t_col           r_start_mem [ROWS];
    t_col           r_rd_data;
    logic           r_out_valid;
    t_row           r_span_row;
    t_col           r_span_first;
    t_col           r_span_final;
    logic           r_last;

    t_col           n_col;
    logic [RW1-1:0] n_top, n_bot;
    logic [RW1-1:0] nt1, nb1;
    logic           more_top, more_bot;
    logic           emit_last;
    logic [RWI-1:0] rd_addr, wr_addr;

    always_comb begin
        n_col = (32'(i_column) >= 32'(COLS)) ? COL_SAT : i_column;
        n_top = clamp_row(i_column_top);
        n_bot = clamp_row(i_column_bottom);
    end

    assign o_status.close_top = (r_t1 < r_t2) && (r_t1 <= r_b1);
    assign o_status.close_bot = (r_b1 > r_b2) && (r_b1 >= r_t1);
    assign o_status.open_top  = (r_t2 < r_t1) && (r_t2 <= r_b2);
    assign o_status.open_bot  = (r_b2 > r_b1) && (r_b2 >= r_t2);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // look one step ahead to flag the final span of the item
    always_comb begin
        nt1       = r_t1 + RW1'(1);
        nb1       = r_b1 - RW1'(1);
        more_top  = (nt1 < r_t2) && (nt1 <= r_b1);
        more_bot  = (r_b1 > r_b2) && (r_b1 >= nt1);
        emit_last = i_cmd.emit_bot ? !((nb1 > r_b2) && (nb1 >= r_t1))
                                   : !(more_top || more_bot);
    end

    assign rd_addr = i_cmd.rd_bot   ? r_b1[RWI-1:0] : r_t1[RWI-1:0];
    assign wr_addr = i_cmd.open_bot ? r_b2[RWI-1:0] : r_t2[RWI-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.open_top || i_cmd.open_bot) begin
            r_start_mem[wr_addr] <= r_col;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_start_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_empty <= 1'b1;
            r_prev_top   <= '0;
            r_prev_bot   <= '0;
        end else if (i_cmd.load) begin
            r_prev_empty <= i_column_empty;
            if (!i_column_empty) begin
                r_prev_top <= n_top;
                r_prev_bot <= n_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= n_col;
            if (i_plane_start || r_prev_empty) begin
                r_t1 <= ROWS_V;
                r_b1 <= '0;
            end else begin
                r_t1 <= r_prev_top;
                r_b1 <= r_prev_bot;
            end
            r_t2 <= i_column_empty ? ROWS_V : n_top;
            r_b2 <= i_column_empty ? '0 : n_bot;
        end else begin
            if (i_cmd.emit && !i_cmd.emit_bot) begin
                r_t1 <= nt1;
            end
            if (i_cmd.emit && i_cmd.emit_bot) begin
                r_b1 <= nb1;
            end
            if (i_cmd.open_top) begin
                r_t2 <= r_t2 + RW1'(1);
            end
            if (i_cmd.open_bot) begin
                r_b2 <= r_b2 - RW1'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_span_row   <= RW'(i_cmd.emit_bot ? r_b1 : r_t1);
            r_span_first <= r_rd_data;
            r_span_final <= r_col - CW'(1);
            r_last       <= emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_span_row   = r_span_row;
    assign o_span_first = r_span_first;
    assign o_span_final = r_span_final;
    assign o_last       = r_last;

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> !(i_cmd.open_top || i_cmd.open_bot))
        else $error("start memory read and write in the same cycle");

    a_emit_row_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !i_cmd.emit_bot) |-> ((r_t1 < r_t2) && (r_t1 <= r_b1)))
        else $error("top span emitted for a row that is not leaving coverage");

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> ((r_t1 <= ROWS_V) && (r_t2 <= ROWS_V) && (r_b2 < ROWS_V)))
        else $error("row range loaded outside the row count");

endmodule

// ----- rtl/column_to_row_span_extractor.sv -----
// each closed row is walked as a start read, then an emit into the output register, and the emit
// waits while the output register is occupied; each opened row writes its start column into the
// single-port span start memory; a new item is taken only in the idle state, after all four row walks
// reset: synchronous active low; clears the sequencer, output valid and previous
// range (previous column empty); the span start memory is not cleared
module column_to_row_span_extractor import cspan_pkg::*; #(
    parameter int ROWS = 64,
    parameter int COLS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cspan_in_if.sink    i_in,
    cspan_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    cspan_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cspan_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_column        (i_in.column),
        .i_column_top    (i_in.column_top),
        .i_column_bottom (i_in.column_bottom),
        .i_column_empty  (i_in.column_empty),
        .i_plane_start   (i_in.plane_start),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_span_row      (o_out.span_row),
        .o_span_first    (o_out.span_first),
        .o_span_final    (o_out.span_final),
        .o_last          (o_out.last)
    );

endmodule

// ----- bench/tb_column_to_row_span_extractor.sv -----
// testbench for column_to_row_span_extractor: directed table then random planes,
// every span compared against hand-typed values or an in-bench row span predictor
// depends on cspan_pkg, cspan_in_if/cspan_out_if and the rtl top level
module tb_column_to_row_span_extractor import cspan_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = 64;
    localparam int DIR_ROWS     = 26;
    localparam int RAND_ITEMS   = 84;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        t_col column;
        t_row top;
        t_row bottom;
        logic empty;
        logic plane_start;
    } t_col_item;

    typedef struct packed {
        t_row row;
        t_col first_col;
        t_col end_col;
        logic tail;
    } t_span;

    // typed rows carry zero or one span, written out by hand
    typedef struct {
        t_col_item item;
        bit        typed;
        int        n_typed;
        t_span     span;
    } t_dir_row;

    t_dir_row dir_table [DIR_ROWS] = '{
        // empty column straight after reset
        '{'{10'd0,    6'd0,  6'd0,  1'b1, 1'b0}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd0,    6'd0,  6'd0,  1'b0, 1'b1}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd1,    6'd0,  6'd0,  1'b1, 1'b0}, 1'b1, 1, '{6'd0,  10'd0,    10'd0,    1'b1}},
        // full height column, then shrink from both sides, then close at 1023
        '{'{10'd0,    6'd0,  6'd63, 1'b0, 1'b1}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd5,    6'd1,  6'd62, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd1023, 6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        // column zero: end column wraps
        '{'{10'd1000, 6'd10, 6'd10, 1'b0, 1'b1}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd0,    6'd0,  6'd0,  1'b1, 1'b0}, 1'b1, 1, '{6'd10, 10'd1000, 10'd1023, 1'b1}},
        // inverted range covers nothing
        '{'{10'd3,    6'd40, 6'd20, 1'b0, 1'b1}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd4,    6'd20, 6'd40, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd7,    6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        // plane start over a live column, then all 64 rows at once
        '{'{10'd10,   6'd5,  6'd8,  1'b0, 1'b1}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd11,   6'd30, 6'd35, 1'b0, 1'b1}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd12,   6'd0,  6'd63, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd13,   6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd14,   6'd0,  6'd0,  1'b1, 1'b1}, 1'b1, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        // range slides down then up
        '{'{10'd20,   6'd10, 6'd20, 1'b0, 1'b1}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd21,   6'd15, 6'd25, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd22,   6'd5,  6'd18, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd23,   6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        // bottom row alone
        '{'{10'd30,   6'd63, 6'd63, 1'b0, 1'b1}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd31,   6'd0,  6'd62, 1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd32,   6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        // inverted range following a live one
        '{'{10'd40,   6'd5,  6'd10, 1'b0, 1'b1}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd41,   6'd20, 6'd3,  1'b0, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}},
        '{'{10'd42,   6'd0,  6'd0,  1'b1, 1'b0}, 1'b0, 0, '{6'd0,  10'd0,    10'd0,    1'b0}}
    };

    logic i_clk;
    logic i_rst_n;

    cspan_in_if  col_if ();
    cspan_out_if span_if ();

    column_to_row_span_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (col_if),
        .o_out   (span_if)
    );

    // predictor state
    t_col  span_open_col [ROWS];
    t_row  last_top   = '0;
    t_row  last_bot   = '0;
    logic  last_blank = 1'b1;
    t_span new_spans [$];
    t_span pending_spans [$];

    int err_count  = 0;
    int burst_left = 0;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[column_to_row_span_extractor] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("span mismatch on %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic void close_row(input int r, input t_col c);
        t_span s;
        s.row       = t_row'(r);
        s.first_col = span_open_col[t_row'(r)];
        s.end_col   = c - 10'd1;
        s.tail      = 1'b0;
        new_spans.push_back(s);
    endfunction

    // 6-bit rows and 10-bit columns never exceed 64 rows and 1024 columns,
    // so the saturation cases reduce to the plain values
    function automatic void walk_column(input t_col_item it);
        int t_old, b_old, t_cur, b_cur;
        new_spans.delete();
        if (it.plane_start || last_blank) begin
            t_old = ROWS;
            b_old = 0;
        end else begin
            t_old = int'(last_top);
            b_old = int'(last_bot);
        end
        if (it.empty) begin
            t_cur = ROWS;
            b_cur = 0;
        end else begin
            t_cur = int'(it.top);
            b_cur = int'(it.bottom);
        end
        // rows leaving at the top side ascend, at the bottom side descend
        while (t_old < t_cur && t_old <= b_old) begin
            close_row(t_old, it.column);
            t_old++;
        end
        while (b_old > b_cur && b_old >= t_old) begin
            close_row(b_old, it.column);
            b_old--;
        end
        while (t_cur < t_old && t_cur <= b_cur) begin
            span_open_col[t_row'(t_cur)] = it.column;
            t_cur++;
        end
        while (b_cur > b_old && b_cur >= t_cur) begin
            span_open_col[t_row'(b_cur)] = it.column;
            b_cur--;
        end
        if (new_spans.size() != 0)
            new_spans[new_spans.size() - 1].tail = 1'b1;
        last_blank = it.empty;
        if (!it.empty) begin
            last_top = it.top;
            last_bot = it.bottom;
        end
    endfunction

    task automatic send_column(input t_col_item it);
        col_if.valid         <= 1'b1;
        col_if.column        <= it.column;
        col_if.column_top    <= it.top;
        col_if.column_bottom <= it.bottom;
        col_if.column_empty  <= it.empty;
        col_if.plane_start   <= it.plane_start;
        @(posedge i_clk);
        while (!col_if.ready) @(posedge i_clk);
        walk_column(it);
    endtask

    task automatic space_items();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            col_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_spans();
        col_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_spans.size() != 0) @(posedge i_clk);
    endtask

    // receiver: ready follows a 16-bit pattern that is redrawn at random
    initial begin
        bit [15:0] ready_pattern;
        int        pat_count;
        t_span     want;
        ready_pattern = 16'hffff;
        pat_count     = 0;
        span_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && span_if.valid && span_if.ready) begin
                if (pending_spans.size() == 0) begin
                    report_mismatch("unexpected span_row", int'(span_if.span_row), -1);
                end else begin
                    want = pending_spans.pop_front();
                    if (span_if.span_row != want.row)
                        report_mismatch("span_row", int'(span_if.span_row), int'(want.row));
                    if (span_if.span_first != want.first_col)
                        report_mismatch("span_first", int'(span_if.span_first),
                                        int'(want.first_col));
                    if (span_if.span_final != want.end_col)
                        report_mismatch("span_final", int'(span_if.span_final),
                                        int'(want.end_col));
                    if (span_if.last != want.tail)
                        report_mismatch("last", int'(span_if.last), int'(want.tail));
                end
            end
            if (pat_count % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    ready_pattern = 16'hffff;
                    2:       ready_pattern = 16'($urandom);
                    3:       ready_pattern = 16'h8001;
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            span_if.ready <= ready_pattern[pat_count[3:0]];
            pat_count++;
        end
    end

    initial begin
        t_col_item it;
        bit        in_plane;
        t_col      plane_col;
        int        plane_top, plane_bot;
        i_rst_n              = 1'b0;
        col_if.valid         = 1'b0;
        col_if.column        = '0;
        col_if.column_top    = '0;
        col_if.column_bottom = '0;
        col_if.column_empty  = 1'b0;
        col_if.plane_start   = 1'b0;
        in_plane  = 1'b0;
        plane_col = '0;
        plane_top = 0;
        plane_bot = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[k]) begin
            send_column(dir_table[k].item);
            if (dir_table[k].typed) begin
                if (dir_table[k].n_typed == 1)
                    pending_spans.push_back(dir_table[k].span);
            end else begin
                foreach (new_spans[j]) pending_spans.push_back(new_spans[j]);
            end
            space_items();
        end
        drain_spans();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 11) == 0) begin
                // noise: any field combination
                it.column      = t_col'($urandom);
                it.top         = t_row'($urandom);
                it.bottom      = t_row'($urandom);
                it.empty       = 1'($urandom);
                it.plane_start = 1'($urandom);
            end else if (!in_plane) begin
                plane_col      = t_col'($urandom_range(0, 1023));
                plane_top      = $urandom_range(0, 63);
                plane_bot      = $urandom_range(plane_top, 63);
                it.column      = plane_col;
                it.top         = t_row'(plane_top);
                it.bottom      = t_row'(plane_bot);
                it.empty       = 1'b0;
                it.plane_start = 1'b1;
                in_plane       = 1'b1;
            end else begin
                plane_col      = plane_col + t_col'($urandom_range(1, 3));
                it.column      = plane_col;
                it.plane_start = 1'b0;
                if ($urandom_range(0, 9) == 0) begin
                    // empty column ends the plane
                    it.top    = t_row'($urandom);
                    it.bottom = t_row'($urandom);
                    it.empty  = 1'b1;
                    in_plane  = 1'b0;
                end else begin
                    if ($urandom_range(0, 14) == 0) begin
                        plane_top = $urandom_range(0, 63);
                        plane_bot = $urandom_range(0, 63);
                    end else begin
                        plane_top = plane_top + int'($urandom_range(0, 4)) - 2;
                        plane_bot = plane_bot + int'($urandom_range(0, 4)) - 2;
                        plane_top = (plane_top < 0) ? 0 : (plane_top > 63) ? 63 : plane_top;
                        plane_bot = (plane_bot < 0) ? 0 : (plane_bot > 63) ? 63 : plane_bot;
                    end
                    it.top    = t_row'(plane_top);
                    it.bottom = t_row'(plane_bot);
                    it.empty  = 1'b0;
                end
            end
            send_column(it);
            foreach (new_spans[j]) pending_spans.push_back(new_spans[j]);
            if (n % 37 == 36)
                drain_spans();
            else
                space_items();
        end

        drain_spans();
        // the last item may still be walking its opened rows
        repeat (300) @(posedge i_clk);
        if (err_count == 0)
            $display("[column_to_row_span_extractor] OK");
        else
            $display("[column_to_row_span_extractor] ERROR");
        $finish;
    end

endmodule
